[src/hbmt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbmt_pkg
// Shared types and codes for the heartbeat membership table.
// ----------------------------------------------------------------------------
package hbmt_pkg;

   localparam logic [2:0] CMD_JOIN_REQ   = 3'd0;
   localparam logic [2:0] CMD_JOIN_REPLY = 3'd1;
   localparam logic [2:0] CMD_HEARTBEAT  = 3'd2;
   localparam logic [2:0] CMD_GOSSIP     = 3'd3;
   localparam logic [2:0] CMD_TICK       = 3'd4;

   localparam logic [2:0] EV_ADDED     = 3'd0;
   localparam logic [2:0] EV_UPDATED   = 3'd1;
   localparam logic [2:0] EV_UNCHANGED = 3'd2;
   localparam logic [2:0] EV_REMOVED   = 3'd3;
   localparam logic [2:0] EV_DROPPED   = 3'd4;
   localparam logic [2:0] EV_IGNORED   = 3'd5;
   localparam logic [2:0] EV_DONE      = 3'd6;

   localparam logic [1:0] CSR_SELF_ID   = 2'd0;
   localparam logic [1:0] CSR_SELF_PORT = 2'd1;
   localparam logic [1:0] CSR_TIMEOUT   = 2'd2;
   localparam logic [1:0] CSR_IN_GROUP  = 2'd3;

   localparam logic [15:0] TIMEOUT_RESET = 16'd20;

   typedef struct packed {
      logic [2:0]  command;
      logic [31:0] node_id;
      logic [15:0] node_port;
      logic [31:0] beat_value;
      logic [31:0] entry_time;
      logic [31:0] now;
   } req_type;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [31:0] member_id;
      logic [15:0] member_port;
      logic [31:0] member_beat;
      logic [31:0] own_beat;
      logic [5:0]  member_count;
      logic        in_group;
      logic        reply_needed;
      logic        last;
   } rsp_type;

endpackage

[src/hbmt_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbmt_front
// Accepts requests into a two-entry queue toward the table engine.
// ----------------------------------------------------------------------------
module hbmt_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire hbmt_pkg::req_type req_data,
   output logic                   busy,
   input  wire logic              pop,
   output logic                   q_valid,
   output hbmt_pkg::req_type      q_data
);

   hbmt_pkg::req_type mem_ff [2];
   logic wp_ff, rp_ff;
   logic [1:0] cnt_ff, cnt_in;
   logic push;

   assign busy    = cnt_ff[1];
   assign push    = start && !busy;
   assign q_valid = cnt_ff != 2'd0;
   assign q_data  = mem_ff[rp_ff];
   assign cnt_in  = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= req_data;
      end
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop)  rp_ff <= !rp_ff;
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

[src/hbmt_engine.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbmt_engine
// Table engine: parallel match for messages, slot walk for ticks.
// ----------------------------------------------------------------------------
module hbmt_engine #(
   parameter int TABLE_DEPTH = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_valid,
   input  wire hbmt_pkg::req_type q_data,
   output logic                   pop,
   input  wire logic              csr_write,
   input  wire logic [1:0]        csr_index,
   input  wire logic [31:0]       csr_data,
   output logic                   rsp_strobe,
   output hbmt_pkg::rsp_type      rsp_data
);

   localparam int IW = $clog2(TABLE_DEPTH);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_WALK = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0] st_ff, st_in;
   hbmt_pkg::req_type cur_ff;
   logic [TABLE_DEPTH-1:0] valid_ff;
   logic [31:0] id_ff   [TABLE_DEPTH];
   logic [15:0] port_ff [TABLE_DEPTH];
   logic [31:0] beat_ff [TABLE_DEPTH];
   logic [31:0] seen_ff [TABLE_DEPTH];
   logic [31:0] own_ff;
   logic        grp_ff;
   logic [31:0] self_id_ff;
   logic [15:0] self_port_ff;
   logic [15:0] tmo_ff;
   logic [5:0]  count_ff;
   logic [IW-1:0] walk_ff;
   logic [TABLE_DEPTH-1:0] hit;
   logic        found, has_free;
   logic [IW-1:0] hit_idx, free_idx;
   logic [31:0] hbeat, hseen, wage;

   always_comb begin
      found = 1'b0; hit_idx = '0; has_free = 1'b0; free_idx = '0;
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
         hit[i] = valid_ff[i] && id_ff[i] == cur_ff.node_id
                  && port_ff[i] == cur_ff.node_port;
         if (hit[i]) begin
            found = 1'b1; hit_idx = IW'(i);
         end
         if (!valid_ff[i]) begin
            has_free = 1'b1; free_idx = IW'(i);
         end
      end
   end

   assign hbeat = beat_ff[hit_idx];
   assign hseen = cur_ff.now - seen_ff[walk_ff];
   assign wage  = cur_ff.now - cur_ff.entry_time;
   assign pop   = st_ff == ST_IDLE && q_valid;

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: if (q_valid) st_in = ST_EXEC;
         ST_EXEC: begin
            if (cur_ff.command == hbmt_pkg::CMD_TICK && grp_ff) st_in = ST_WALK;
            else st_in = ST_IDLE;
         end
         ST_WALK: if (walk_ff == IW'(TABLE_DEPTH - 1)) st_in = ST_DONE;
         ST_DONE: st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_strobe <= 1'b0;
      rsp_data.last <= 1'b0;
      rsp_data.reply_needed <= cur_ff.command == hbmt_pkg::CMD_JOIN_REQ;
      if (st_ff == ST_IDLE && q_valid) cur_ff <= q_data;
      case (st_ff)
         ST_EXEC: begin
            rsp_strobe <= 1'b1;
            rsp_data.last <= 1'b1;
            rsp_data.member_id <= cur_ff.node_id;
            rsp_data.member_port <= cur_ff.node_port;
            rsp_data.member_beat <= 32'd0;
            rsp_data.event_res <= hbmt_pkg::EV_IGNORED;
            rsp_data.member_count <= count_ff;
            rsp_data.own_beat <= own_ff;
            rsp_data.in_group <= grp_ff;
            walk_ff <= '0;
            case (cur_ff.command)
               hbmt_pkg::CMD_JOIN_REQ, hbmt_pkg::CMD_JOIN_REPLY,
               hbmt_pkg::CMD_HEARTBEAT, hbmt_pkg::CMD_GOSSIP: begin
                  if (cur_ff.command == hbmt_pkg::CMD_JOIN_REPLY) begin
                     grp_ff <= 1'b1;
                     rsp_data.in_group <= 1'b1;
                  end
                  if (found) begin
                     if (cur_ff.command == hbmt_pkg::CMD_HEARTBEAT) begin
                        beat_ff[hit_idx] <= hbeat < cur_ff.beat_value ?
                                            cur_ff.beat_value : hbeat + 32'd1;
                        seen_ff[hit_idx] <= cur_ff.now;
                        rsp_data.event_res <= hbmt_pkg::EV_UPDATED;
                        rsp_data.member_beat <= hbeat < cur_ff.beat_value ?
                                                cur_ff.beat_value : hbeat + 32'd1;
                     end else if (cur_ff.command == hbmt_pkg::CMD_GOSSIP
                                  && hbeat < cur_ff.beat_value) begin
                        beat_ff[hit_idx] <= cur_ff.beat_value;
                        seen_ff[hit_idx] <= cur_ff.now;
                        rsp_data.event_res <= hbmt_pkg::EV_UPDATED;
                        rsp_data.member_beat <= cur_ff.beat_value;
                     end else begin
                        rsp_data.event_res <= hbmt_pkg::EV_UNCHANGED;
                        rsp_data.member_beat <= hbeat;
                     end
                  end else if (cur_ff.command == hbmt_pkg::CMD_GOSSIP
                               && ((cur_ff.node_id == self_id_ff
                                    && cur_ff.node_port == self_port_ff)
                                   || wage >= {16'd0, tmo_ff})) begin
                     rsp_data.event_res <= hbmt_pkg::EV_IGNORED;
                  end else if (!has_free) begin
                     rsp_data.event_res <= hbmt_pkg::EV_DROPPED;
                  end else begin
                     valid_ff[free_idx] <= 1'b1;
                     id_ff[free_idx] <= cur_ff.node_id;
                     port_ff[free_idx] <= cur_ff.node_port;
                     count_ff <= count_ff + 6'd1;
                     rsp_data.member_count <= count_ff + 6'd1;
                     rsp_data.event_res <= hbmt_pkg::EV_ADDED;
                     if (cur_ff.command == hbmt_pkg::CMD_GOSSIP) begin
                        beat_ff[free_idx] <= cur_ff.beat_value;
                        seen_ff[free_idx] <= cur_ff.entry_time;
                        rsp_data.member_beat <= cur_ff.beat_value;
                     end else begin
                        beat_ff[free_idx] <= 32'd1;
                        seen_ff[free_idx] <= cur_ff.now;
                        rsp_data.member_beat <= 32'd1;
                     end
                  end
               end
               hbmt_pkg::CMD_TICK: begin
                  rsp_data.member_id <= 32'd0;
                  rsp_data.member_port <= 16'd0;
                  if (grp_ff) begin
                     own_ff <= own_ff + 32'd1;
                     rsp_strobe <= 1'b0;
                  end
               end
               default: begin
                  rsp_data.member_id <= 32'd0;
                  rsp_data.member_port <= 16'd0;
               end
            endcase
         end
         ST_WALK: begin
            walk_ff <= walk_ff + IW'(1);
            if (valid_ff[walk_ff] && hseen >= {16'd0, tmo_ff}) begin
               valid_ff[walk_ff] <= 1'b0;
               count_ff <= count_ff - 6'd1;
               rsp_strobe <= 1'b1;
               rsp_data.event_res <= hbmt_pkg::EV_REMOVED;
               rsp_data.member_id <= id_ff[walk_ff];
               rsp_data.member_port <= port_ff[walk_ff];
               rsp_data.member_beat <= beat_ff[walk_ff];
               rsp_data.member_count <= count_ff - 6'd1;
               rsp_data.own_beat <= own_ff;
               rsp_data.in_group <= grp_ff;
            end
         end
         ST_DONE: begin
            rsp_strobe <= 1'b1;
            rsp_data.last <= 1'b1;
            rsp_data.event_res <= hbmt_pkg::EV_DONE;
            rsp_data.member_id <= 32'd0;
            rsp_data.member_port <= 16'd0;
            rsp_data.member_beat <= 32'd0;
            rsp_data.member_count <= count_ff;
            rsp_data.own_beat <= own_ff;
            rsp_data.in_group <= grp_ff;
         end
         default: ;
      endcase
      if (csr_write) begin
         case (csr_index)
            hbmt_pkg::CSR_SELF_ID:   self_id_ff <= csr_data;
            hbmt_pkg::CSR_SELF_PORT: self_port_ff <= csr_data[15:0];
            hbmt_pkg::CSR_TIMEOUT:   tmo_ff <= csr_data[15:0];
            hbmt_pkg::CSR_IN_GROUP:  grp_ff <= csr_data[0];
            default: ;
         endcase
      end
      if (reset) begin
         st_ff <= ST_IDLE;
         rsp_strobe <= 1'b0;
         valid_ff <= '0;
         count_ff <= 6'd0;
         own_ff <= 32'd0;
         grp_ff <= 1'b0;
         self_id_ff <= 32'd0;
         self_port_ff <= 16'd0;
         tmo_ff <= hbmt_pkg::TIMEOUT_RESET;
      end else begin
         st_ff <= st_in;
      end
   end

endmodule
`default_nettype wire

[src/heartbeat_membership_table.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// heartbeat_membership_table
// Gossip heartbeat failure detector with a member table.
// ----------------------------------------------------------------------------
// channel  ports                       handshake
// request  start, busy, req_data       taken when start && !busy
// response rsp_strobe, rsp_data        one-cycle strobe per result, no stall
// config   csr_write, csr_index, csr_data  written when csr_write
//
// A message passes the queue, the match and the result register. A tick
// in the group walks the table slots, one slot per cycle, then ends with done.
// A two-entry queue holds requests while the engine works; busy when full.
// Synchronous reset clears the table valid bits at once.
// ----------------------------------------------------------------------------
module heartbeat_membership_table #(
   parameter int TABLE_DEPTH = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire hbmt_pkg::req_type req_data,
   output logic                   busy,
   output logic                   rsp_strobe,
   output hbmt_pkg::rsp_type      rsp_data,
   input  wire logic              csr_write,
   input  wire logic [1:0]        csr_index,
   input  wire logic [31:0]       csr_data
);

   logic q_valid, pop;
   hbmt_pkg::req_type q_data;

   hbmt_front u_front (
      .clock, .reset, .start, .req_data, .busy, .pop, .q_valid, .q_data
   );

   hbmt_engine #(.TABLE_DEPTH(TABLE_DEPTH)) u_engine (
      .clock, .reset, .q_valid, .q_data, .pop, .csr_write, .csr_index,
      .csr_data, .rsp_strobe, .rsp_data
   );

endmodule
`default_nettype wire

[tb/tb_heartbeat_membership_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_heartbeat_membership_table
// Drives join, heartbeat, gossip, tick and unknown-command requests into the
// membership table and checks every response against an in-bench table model.
// ----------------------------------------------------------------------------
module tb_heartbeat_membership_table;

   localparam int DEPTH = 32;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [2:0] CMD_UNKNOWN_LO = 3'd5;
   localparam logic [2:0] CMD_UNKNOWN_HI = 3'd7;

   logic clock;
   logic reset;
   logic start;
   hbmt_pkg::req_type req_data;
   logic busy;
   logic rsp_strobe;
   hbmt_pkg::rsp_type rsp_data;
   logic csr_write;
   logic [1:0] csr_index;
   logic [31:0] csr_data;

   heartbeat_membership_table #(.TABLE_DEPTH(DEPTH)) dut (
      .clock(clock), .reset(reset), .start(start), .req_data(req_data),
      .busy(busy), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   // model state
   logic        mv_valid [DEPTH];
   logic [31:0] mv_id    [DEPTH];
   logic [15:0] mv_port  [DEPTH];
   logic [31:0] mv_beat  [DEPTH];
   logic [31:0] mv_seen  [DEPTH];
   logic [31:0] m_own;
   logic        m_group;
   logic        m_reply;
   logic [31:0] m_self_id;
   logic [15:0] m_self_port;
   logic [15:0] m_timeout;

   hbmt_pkg::rsp_type expected_rsps[$];
   int mismatches;
   int cycles;
   bit idle_gaps;

   // ids from a small pool so matches happen
   logic [31:0] id_pool [8];
   logic [15:0] port_pool [8];
   logic [31:0] clock_now;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [5:0] table_count();
      int n;
      n = 0;
      for (int i = 0; i < DEPTH; i++) n += mv_valid[i];
      return n[5:0];
   endfunction

   function automatic void push_rsp(logic [2:0] ev, logic [31:0] id, logic [15:0] port,
                                    logic [31:0] beat);
      hbmt_pkg::rsp_type r;
      r.event_res = ev;
      r.member_id = id;
      r.member_port = port;
      r.member_beat = beat;
      r.own_beat = m_own;
      r.member_count = table_count();
      r.in_group = m_group;
      r.reply_needed = m_reply;
      r.last = 1'b0;
      expected_rsps.insert(expected_rsps.size(), r);
   endfunction

   function automatic int find_member(logic [31:0] id, logic [15:0] port);
      for (int i = 0; i < DEPTH; i++)
         if (mv_valid[i] && mv_id[i] == id && mv_port[i] == port) return i;
      return -1;
   endfunction

   function automatic void insert_member(logic [31:0] id, logic [15:0] port,
                                         logic [31:0] beat, logic [31:0] seen);
      for (int i = 0; i < DEPTH; i++) begin
         if (!mv_valid[i]) begin
            mv_valid[i] = 1'b1;
            mv_id[i] = id;
            mv_port[i] = port;
            mv_beat[i] = beat;
            mv_seen[i] = seen;
            push_rsp(hbmt_pkg::EV_ADDED, id, port, beat);
            return;
         end
      end
      push_rsp(hbmt_pkg::EV_DROPPED, id, port, 32'd0);
   endfunction

   function automatic void predict_request(hbmt_pkg::req_type q);
      int i;
      hbmt_pkg::rsp_type r;
      m_reply = (q.command == hbmt_pkg::CMD_JOIN_REQ);
      case (q.command)
         hbmt_pkg::CMD_JOIN_REQ, hbmt_pkg::CMD_JOIN_REPLY: begin
            if (q.command == hbmt_pkg::CMD_JOIN_REPLY) m_group = 1'b1;
            i = find_member(q.node_id, q.node_port);
            if (i >= 0)
               push_rsp(hbmt_pkg::EV_UNCHANGED, q.node_id, q.node_port, mv_beat[i]);
            else insert_member(q.node_id, q.node_port, 32'd1, q.now);
         end
         hbmt_pkg::CMD_HEARTBEAT: begin
            i = find_member(q.node_id, q.node_port);
            if (i >= 0) begin
               if (mv_beat[i] < q.beat_value) mv_beat[i] = q.beat_value;
               else mv_beat[i] = mv_beat[i] + 32'd1;
               mv_seen[i] = q.now;
               push_rsp(hbmt_pkg::EV_UPDATED, q.node_id, q.node_port, mv_beat[i]);
            end else insert_member(q.node_id, q.node_port, 32'd1, q.now);
         end
         hbmt_pkg::CMD_GOSSIP: begin
            i = find_member(q.node_id, q.node_port);
            if (i >= 0) begin
               if (mv_beat[i] < q.beat_value) begin
                  mv_beat[i] = q.beat_value;
                  mv_seen[i] = q.now;
                  push_rsp(hbmt_pkg::EV_UPDATED, q.node_id, q.node_port, q.beat_value);
               end else
                  push_rsp(hbmt_pkg::EV_UNCHANGED, q.node_id, q.node_port, mv_beat[i]);
            end else if (q.node_id == m_self_id && q.node_port == m_self_port)
               push_rsp(hbmt_pkg::EV_IGNORED, q.node_id, q.node_port, 32'd0);
            else if ((q.now - q.entry_time) < {16'd0, m_timeout})
               insert_member(q.node_id, q.node_port, q.beat_value, q.entry_time);
            else push_rsp(hbmt_pkg::EV_IGNORED, q.node_id, q.node_port, 32'd0);
         end
         hbmt_pkg::CMD_TICK: begin
            if (!m_group) push_rsp(hbmt_pkg::EV_IGNORED, 32'd0, 16'd0, 32'd0);
            else begin
               m_own = m_own + 32'd1;
               for (int s = 0; s < DEPTH; s++) begin
                  if (mv_valid[s] && (q.now - mv_seen[s]) >= {16'd0, m_timeout}) begin
                     mv_valid[s] = 1'b0;
                     push_rsp(hbmt_pkg::EV_REMOVED, mv_id[s], mv_port[s], mv_beat[s]);
                  end
               end
               push_rsp(hbmt_pkg::EV_DONE, 32'd0, 16'd0, 32'd0);
            end
         end
         default: push_rsp(hbmt_pkg::EV_IGNORED, 32'd0, 16'd0, 32'd0);
      endcase
      r = expected_rsps[expected_rsps.size() - 1];
      r.last = 1'b1;
      expected_rsps[expected_rsps.size() - 1] = r;
   endfunction

   // response checker
   always @(posedge clock) begin
      hbmt_pkg::rsp_type e;
      if (!reset && rsp_strobe) begin
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", rsp_data);
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_data !== e) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: expected %p actual %p", e, rsp_data);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic random_gap();
      if (idle_gaps && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   task automatic send_request(logic [2:0] cmd, logic [31:0] id, logic [15:0] port,
                               logic [31:0] beat, logic [31:0] etime);
      hbmt_pkg::req_type q;
      random_gap();
      q.command = cmd;
      q.node_id = id;
      q.node_port = port;
      q.beat_value = beat;
      q.entry_time = etime;
      q.now = clock_now;
      start <= 1'b1;
      req_data <= q;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_request(q);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (DEPTH + 10) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [31:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         hbmt_pkg::CSR_SELF_ID:   m_self_id = val;
         hbmt_pkg::CSR_SELF_PORT: m_self_port = val[15:0];
         hbmt_pkg::CSR_TIMEOUT:   m_timeout = val[15:0];
         hbmt_pkg::CSR_IN_GROUP:  m_group = val[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic test_directed();
      // tick before joining group, unknown commands
      send_request(hbmt_pkg::CMD_TICK, 32'd0, 16'd0, 32'd0, 32'd0);
      send_request(CMD_UNKNOWN_LO, 32'hFFFFFFFF, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
      send_request(CMD_UNKNOWN_HI, 32'd0, 16'd0, 32'd0, 32'd0);
      send_request(hbmt_pkg::CMD_JOIN_REQ, 32'hFFFFFFFF, 16'hFFFF, 32'd0, 32'd0);
      send_request(hbmt_pkg::CMD_JOIN_REQ, 32'hFFFFFFFF, 16'hFFFF, 32'd0, 32'd0);
      send_request(hbmt_pkg::CMD_JOIN_REPLY, 32'd0, 16'd0, 32'd0, 32'd0);
      send_request(hbmt_pkg::CMD_HEARTBEAT, 32'd0, 16'd0, 32'hFFFFFFFF, 32'd0);
      send_request(hbmt_pkg::CMD_HEARTBEAT, 32'd0, 16'd0, 32'd5, 32'd0);
      send_request(hbmt_pkg::CMD_HEARTBEAT, 32'h12345678, 16'h8000, 32'd7, 32'd0);
      send_request(hbmt_pkg::CMD_GOSSIP, 32'h12345678, 16'h8000, 32'd100, 32'd0);
      send_request(hbmt_pkg::CMD_GOSSIP, 32'h12345678, 16'h8000, 32'd3, 32'd0);
      send_request(hbmt_pkg::CMD_GOSSIP, m_self_id, m_self_port, 32'd9, clock_now);
      clock_now = 32'd5;
      send_request(hbmt_pkg::CMD_GOSSIP, 32'hA5A5A5A5, 16'h5A5A, 32'd9, 32'hFFFFFFFE);
      send_request(hbmt_pkg::CMD_GOSSIP, 32'h0F0F0F0F, 16'h0F0F, 32'd9, 32'd5 - 32'd20);
      send_request(hbmt_pkg::CMD_TICK, 32'd0, 16'd0, 32'd0, 32'd0);
      clock_now = 32'd40;
      send_request(hbmt_pkg::CMD_TICK, 32'd0, 16'd0, 32'd0, 32'd0);
      wait_drained();
   endtask

   task automatic test_full_table();
      for (int i = 0; i < DEPTH + 3; i++)
         send_request(hbmt_pkg::CMD_HEARTBEAT, 32'h1000 + i, 16'(i), 32'd0, 32'd0);
      clock_now = clock_now + 32'd100;
      send_request(hbmt_pkg::CMD_TICK, 32'd0, 16'd0, 32'd0, 32'd0);
      wait_drained();
   endtask

   task automatic test_zero_timeout();
      write_csr(hbmt_pkg::CSR_TIMEOUT, 32'd0);
      send_request(hbmt_pkg::CMD_JOIN_REQ, 32'h55, 16'h55, 32'd0, 32'd0);
      send_request(hbmt_pkg::CMD_GOSSIP, 32'h66, 16'h66, 32'd4, clock_now);
      send_request(hbmt_pkg::CMD_TICK, 32'd0, 16'd0, 32'd0, 32'd0);
      wait_drained();
      write_csr(hbmt_pkg::CSR_TIMEOUT, 32'hFFFF);
      send_request(hbmt_pkg::CMD_GOSSIP, 32'h77, 16'h77, 32'd4, clock_now - 32'hFFFE);
      send_request(hbmt_pkg::CMD_TICK, 32'd0, 16'd0, 32'd0, 32'd0);
      wait_drained();
   endtask

   task automatic test_random(int count);
      logic [2:0] cmd;
      int k;
      for (int n = 0; n < count; n++) begin
         if (count > 40 && n == count - 40) idle_gaps = 1'b0;
         if (n == count / 2) wait_drained();
         k = $urandom_range(0, 7);
         clock_now = clock_now + $urandom_range(0, 3);
         case ($urandom_range(0, 19))
            0, 1, 2: cmd = hbmt_pkg::CMD_HEARTBEAT;
            3, 4, 5, 6: cmd = hbmt_pkg::CMD_GOSSIP;
            7, 8, 9: cmd = hbmt_pkg::CMD_TICK;
            10: cmd = hbmt_pkg::CMD_JOIN_REQ;
            11: cmd = hbmt_pkg::CMD_JOIN_REPLY;
            12: cmd = 3'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI));
            default: cmd = 3'($urandom_range(hbmt_pkg::CMD_JOIN_REQ, hbmt_pkg::CMD_GOSSIP));
         endcase
         if ($urandom_range(0, 9) == 0)
            send_request(cmd, $urandom, 16'($urandom), $urandom, $urandom);
         else
            send_request(cmd, id_pool[k], port_pool[k], $urandom_range(0, 40),
                         clock_now - $urandom_range(0, 2 * m_timeout));
      end
      wait_drained();
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data = '0;
      cycles = 0;
      mismatches = 0;
      idle_gaps = 1'b1;
      clock_now = 32'hFFFFFFF0;
      for (int i = 0; i < DEPTH; i++) mv_valid[i] = 1'b0;
      m_own = '0;
      m_group = 1'b0;
      m_reply = 1'b0;
      m_self_id = '0;
      m_self_port = '0;
      m_timeout = hbmt_pkg::TIMEOUT_RESET;
      for (int i = 0; i < 8; i++) begin
         id_pool[i] = $urandom;
         port_pool[i] = 16'($urandom);
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_csr(hbmt_pkg::CSR_SELF_ID, 32'hFFFFFFFF);
      write_csr(hbmt_pkg::CSR_SELF_PORT, 32'h0000FFFF);
      test_directed();
      test_full_table();
      test_zero_timeout();
      write_csr(hbmt_pkg::CSR_SELF_ID, id_pool[0]);
      write_csr(hbmt_pkg::CSR_SELF_PORT, {16'd0, port_pool[0]});
      write_csr(hbmt_pkg::CSR_TIMEOUT, 32'd1);
      write_csr(hbmt_pkg::CSR_IN_GROUP, 32'd0);
      test_random(40);
      write_csr(hbmt_pkg::CSR_TIMEOUT, 32'd12);
      write_csr(hbmt_pkg::CSR_IN_GROUP, 32'd1);
      test_random(90);
      if (mismatches == 0 && expected_rsps.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
